// ===== sv/bsp_pkg.sv =====
package bsp_pkg;

   // width of the row, column and size fields
   localparam int DIM_BITS = 17;

   typedef logic [DIM_BITS-1:0] dim_type;
   typedef logic [2:0]          kind_type;

   // result kinds
   localparam kind_type KIND_PIXEL     = 3'd0;
   localparam kind_type KIND_ACCEPT    = 3'd1;
   localparam kind_type KIND_BAD       = 3'd2;
   localparam kind_type KIND_PREMATURE = 3'd3;
   localparam kind_type KIND_COMPLETE  = 3'd4;

   // reset value of both size limits
   localparam dim_type LIMIT_RESET = DIM_BITS'(100000);

   // one result as delivered on the result channel
   typedef struct packed {
      kind_type     kind;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      dim_type      pixel_row;
      dim_type      pixel_column;
      dim_type      image_width;
      dim_type      image_height;
      logic         last_of_run;
   } result_type;

   // up to two results produced by one byte
   typedef struct packed {
      logic [1:0]   count;
      result_type   first_res;
      result_type   second_res;
   } push_type;

   // result queue geometry
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = RSP_PTR_BITS + 1;

   typedef logic [RSP_PTR_BITS-1:0] rsp_ptr_type;
   typedef logic [RSP_CNT_BITS-1:0] rsp_cnt_type;

endpackage

// ===== sv/bsp_parse_core.sv =====
module bsp_parse_core import bsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  logic       first_byte,
   input  logic       last_byte,
   input  dim_type    max_columns,
   input  dim_type    max_rows,
   output push_type   push
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_HEADER,
      MODE_PIXELS,
      MODE_PADDING
   } mode_type;

   // header byte positions
   localparam logic [5:0] HDR_SIG_M    = 6'd1;
   localparam logic [5:0] HDR_WIDTH_LO = 6'd18;
   localparam logic [5:0] HDR_WIDTH_HI = 6'd21;
   localparam logic [5:0] HDR_HGT_LO   = 6'd22;
   localparam logic [5:0] HDR_HGT_HI   = 6'd25;
   localparam logic [5:0] HDR_DEPTH_LO = 6'd28;
   localparam logic [5:0] HDR_DEPTH_HI = 6'd29;
   localparam logic [5:0] HDR_LAST     = 6'd53;

   localparam logic [7:0]  CHAR_B         = 8'h42;
   localparam logic [7:0]  CHAR_M         = 8'h4d;
   localparam logic [15:0] REQUIRED_DEPTH = 16'd24;

   mode_type    mode_ff, mode_in;
   logic [5:0]  hdr_idx_ff, hdr_idx_in;
   logic [31:0] width_word_ff, width_word_in;
   logic [31:0] height_word_ff, height_word_in;
   logic [15:0] depth_word_ff, depth_word_in;
   logic        sig_ok_ff, sig_ok_in;
   logic [7:0]  blue_ff, blue_in;
   logic [7:0]  green_ff, green_in;
   logic [1:0]  phase_ff, phase_in;
   dim_type     col_ff, col_in;
   dim_type     row_ff, row_in;
   logic [1:0]  pad_ff, pad_in;

   mode_type    cur_mode;
   result_type  res_v [2];
   logic [1:0]  cnt_v;
   logic        done_v;
   logic        ok_v;
   logic        row_end_v;
   logic [5:0]  offset_v;

   function automatic result_type mk_result(kind_type kind);
      result_type r;
      r      = '0;
      r.kind = kind;
      return r;
   endfunction

   // next state and results of one byte
   always_comb begin
      mode_in        = mode_ff;
      hdr_idx_in     = hdr_idx_ff;
      width_word_in  = width_word_ff;
      height_word_in = height_word_ff;
      depth_word_in  = depth_word_ff;
      sig_ok_in      = sig_ok_ff;
      blue_in        = blue_ff;
      green_in       = green_ff;
      phase_in       = phase_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      pad_in         = pad_ff;
      res_v[0]       = '0;
      res_v[1]       = '0;
      cnt_v          = 2'd0;
      done_v         = 1'b0;
      ok_v           = 1'b0;
      row_end_v      = 1'b0;
      offset_v       = 6'd0;
      cur_mode       = mode_ff;

      if (fire) begin
         // first byte restarts the parse
         if (first_byte) begin
            cur_mode       = MODE_HEADER;
            mode_in        = MODE_HEADER;
            hdr_idx_in     = 6'd0;
            width_word_in  = '0;
            height_word_in = '0;
            depth_word_in  = '0;
            sig_ok_in      = 1'b0;
            blue_in        = '0;
            green_in       = '0;
            phase_in       = 2'd0;
            col_in         = '0;
            row_in         = '0;
            pad_in         = 2'd0;
         end

         unique case (cur_mode)
            MODE_HEADER: begin
               // signature and field capture
               if (hdr_idx_in == 6'd0) begin
                  sig_ok_in = (data_byte == CHAR_B);
               end else if (hdr_idx_in == HDR_SIG_M) begin
                  sig_ok_in = sig_ok_in && (data_byte == CHAR_M);
                  if (!sig_ok_in) begin
                     res_v[cnt_v[0]] = mk_result(KIND_BAD);
                     cnt_v           = cnt_v + 2'd1;
                     mode_in         = MODE_IDLE;
                     done_v          = 1'b1;
                  end
               end else if (hdr_idx_in >= HDR_WIDTH_LO && hdr_idx_in <= HDR_WIDTH_HI) begin
                  offset_v = hdr_idx_in - HDR_WIDTH_LO;
                  width_word_in[8*offset_v[1:0] +: 8] = data_byte;
               end else if (hdr_idx_in >= HDR_HGT_LO && hdr_idx_in <= HDR_HGT_HI) begin
                  offset_v = hdr_idx_in - HDR_HGT_LO;
                  height_word_in[8*offset_v[1:0] +: 8] = data_byte;
               end else if (hdr_idx_in >= HDR_DEPTH_LO && hdr_idx_in <= HDR_DEPTH_HI) begin
                  offset_v = hdr_idx_in - HDR_DEPTH_LO;
                  depth_word_in[8*offset_v[0] +: 8] = data_byte;
               end

               if (!done_v) begin
                  if (hdr_idx_in == HDR_LAST) begin
                     // header validation on its final byte
                     ok_v = (width_word_in != 32'd0)
                         && (width_word_in <= 32'(max_columns))
                         && (height_word_in != 32'd0)
                         && (height_word_in <= 32'(max_rows))
                         && (depth_word_in == REQUIRED_DEPTH);
                     if (!ok_v) begin
                        res_v[cnt_v[0]] = mk_result(KIND_BAD);
                        cnt_v           = cnt_v + 2'd1;
                        mode_in         = MODE_IDLE;
                     end else begin
                        res_v[cnt_v[0]]              = mk_result(KIND_ACCEPT);
                        res_v[cnt_v[0]].image_width  = width_word_in[DIM_BITS-1:0];
                        res_v[cnt_v[0]].image_height = height_word_in[DIM_BITS-1:0];
                        cnt_v    = cnt_v + 2'd1;
                        mode_in  = MODE_PIXELS;
                        phase_in = 2'd0;
                        col_in   = '0;
                        row_in   = '0;
                        pad_in   = 2'd0;
                        if (last_byte) begin
                           res_v[cnt_v[0]] = mk_result(KIND_PREMATURE);
                           cnt_v           = cnt_v + 2'd1;
                           mode_in         = MODE_IDLE;
                        end
                     end
                  end else if (last_byte) begin
                     res_v[cnt_v[0]] = mk_result(KIND_BAD);
                     cnt_v           = cnt_v + 2'd1;
                     mode_in         = MODE_IDLE;
                  end else begin
                     hdr_idx_in = hdr_idx_in + 6'd1;
                  end
               end
            end

            MODE_PIXELS, MODE_PADDING: begin
               if (cur_mode == MODE_PADDING) begin
                  // skip row padding
                  pad_in    = pad_in - 2'd1;
                  row_end_v = (pad_in == 2'd0);
               end else if (phase_in == 2'd0) begin
                  blue_in  = data_byte;
                  phase_in = 2'd1;
               end else if (phase_in == 2'd1) begin
                  green_in = data_byte;
                  phase_in = 2'd2;
               end else begin
                  // red byte completes a pixel
                  res_v[cnt_v[0]]              = mk_result(KIND_PIXEL);
                  res_v[cnt_v[0]].red          = data_byte;
                  res_v[cnt_v[0]].green        = green_in;
                  res_v[cnt_v[0]].blue         = blue_in;
                  res_v[cnt_v[0]].pixel_row    = row_in;
                  res_v[cnt_v[0]].pixel_column = col_in;
                  cnt_v    = cnt_v + 2'd1;
                  phase_in = 2'd0;
                  col_in   = col_in + dim_type'(1);
                  if (32'(col_in) == width_word_in) begin
                     pad_in = width_word_in[1:0];
                     if (pad_in == 2'd0) begin
                        row_end_v = 1'b1;
                     end else begin
                        mode_in = MODE_PADDING;
                     end
                  end
               end

               // end of row, and of the image on the last row
               if (row_end_v) begin
                  col_in = '0;
                  row_in = row_in + dim_type'(1);
                  if (32'(row_in) == height_word_in) begin
                     res_v[cnt_v[0]] = mk_result(KIND_COMPLETE);
                     cnt_v           = cnt_v + 2'd1;
                     mode_in         = MODE_IDLE;
                     done_v          = 1'b1;
                  end else begin
                     mode_in = MODE_PIXELS;
                  end
               end

               if (!done_v && last_byte) begin
                  res_v[cnt_v[0]] = mk_result(KIND_PREMATURE);
                  cnt_v           = cnt_v + 2'd1;
                  mode_in         = MODE_IDLE;
               end
            end

            default: begin
               // idle: byte ignored
            end
         endcase
      end

      // mark the final result of this byte
      if (cnt_v == 2'd1) begin
         res_v[0].last_of_run = 1'b1;
      end else if (cnt_v == 2'd2) begin
         res_v[1].last_of_run = 1'b1;
      end

      push.count      = cnt_v;
      push.first_res  = res_v[0];
      push.second_res = res_v[1];
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         hdr_idx_ff     <= 6'd0;
         width_word_ff  <= '0;
         height_word_ff <= '0;
         depth_word_ff  <= '0;
         sig_ok_ff      <= 1'b0;
         phase_ff       <= 2'd0;
         col_ff         <= '0;
         row_ff         <= '0;
         pad_ff         <= 2'd0;
      end else begin
         mode_ff        <= mode_in;
         hdr_idx_ff     <= hdr_idx_in;
         width_word_ff  <= width_word_in;
         height_word_ff <= height_word_in;
         depth_word_ff  <= depth_word_in;
         sig_ok_ff      <= sig_ok_in;
         phase_ff       <= phase_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         pad_ff         <= pad_in;
      end
   end

   // held pixel bytes
   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
   end

endmodule

// ===== sv/bsp_rsp_fifo.sv =====
module bsp_rsp_fifo import bsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       take,
   output logic       out_valid,
   output result_type out_res,
   output logic       room
);

   result_type  rsp_buf_ff [RSP_DEPTH];
   rsp_ptr_type wr_ptr_ff, wr_ptr_in;
   rsp_ptr_type rd_ptr_ff, rd_ptr_in;
   rsp_cnt_type count_ff, count_in;
   logic        pop;

   // head of queue and free space for a two-result byte
   assign out_valid = (count_ff != '0);
   assign out_res   = rsp_buf_ff[rd_ptr_ff];
   assign pop       = out_valid && take;
   assign room      = (count_ff <= rsp_cnt_type'(RSP_DEPTH - 2));

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + rsp_ptr_type'(push.count);
      rd_ptr_in = rd_ptr_ff + rsp_ptr_type'(pop);
      count_in  = count_ff + rsp_cnt_type'(push.count) - rsp_cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage, two writes per cycle at most
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         rsp_buf_ff[wr_ptr_ff] <= push.first_res;
      end
      if (push.count == 2'd2) begin
         rsp_buf_ff[wr_ptr_ff + rsp_ptr_type'(1)] <= push.second_res;
      end
   end

endmodule

// ===== sv/bmp24_stream_parser.sv =====
// 24-bit BMP stream parser. File bytes enter one per transfer on req_, the
// first byte of each file marked by req_first_byte; results leave on rsp_
// as pixels (with row and column in file order), header accepted (with the
// parsed size), bad format, premature end or image complete. The block takes
// one byte per cycle while the result queue has room: a byte is parsed while
// it sits in the input register, and its results enter the four-entry result
// queue as it leaves that register. Most bytes give no result or one; a byte
// that gives two results writes both queue entries at once, and the input
// stalls only while the result queue has fewer than two free entries.
// Size limits are written through csr_ (index 0 width, index 1 height) and
// should be changed only between files.
module bmp24_stream_parser import bsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output kind_type   rsp_kind,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output dim_type    rsp_pixel_row,
   output dim_type    rsp_pixel_column,
   output dim_type    rsp_image_width,
   output dim_type    rsp_image_height,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  dim_type    csr_wdata
);

   localparam logic CSR_MAX_COLUMNS = 1'b0;
   localparam logic CSR_MAX_ROWS    = 1'b1;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_first_ff;
   logic       in_last_ff;
   dim_type    max_columns_ff, max_columns_in;
   dim_type    max_rows_ff, max_rows_in;
   logic       room;
   logic       fire;
   push_type   push;
   result_type head_res;

   // input register, parsed once the queue has room
   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
      end
   end

   // size limit registers
   always_comb begin
      max_columns_in = max_columns_ff;
      max_rows_in    = max_rows_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_COLUMNS: max_columns_in = csr_wdata;
            CSR_MAX_ROWS:    max_rows_in    = csr_wdata;
            default:         max_rows_in    = max_rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_columns_ff <= LIMIT_RESET;
         max_rows_ff    <= LIMIT_RESET;
      end else begin
         max_columns_ff <= max_columns_in;
         max_rows_ff    <= max_rows_in;
      end
   end

   bsp_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .data_byte   (in_data_ff),
      .first_byte  (in_first_ff),
      .last_byte   (in_last_ff),
      .max_columns (max_columns_ff),
      .max_rows    (max_rows_ff),
      .push        (push)
   );

   bsp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .take      (rsp_ready),
      .out_valid (rsp_valid),
      .out_res   (head_res),
      .room      (room)
   );

   // result fields
   assign rsp_kind         = head_res.kind;
   assign rsp_red          = head_res.red;
   assign rsp_green        = head_res.green;
   assign rsp_blue         = head_res.blue;
   assign rsp_pixel_row    = head_res.pixel_row;
   assign rsp_pixel_column = head_res.pixel_column;
   assign rsp_image_width  = head_res.image_width;
   assign rsp_image_height = head_res.image_height;
   assign rsp_last_of_run  = head_res.last_of_run;

   // results only come from a parsed byte
   a_push_needs_fire: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> fire)
      else $error("results pushed without a parsed byte");

   // a waiting byte is held while the queue is short of room
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> in_valid_ff)
      else $error("input byte dropped while queue full");

   // with two results only the second ends the run
   a_two_result_mark: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
         (!push.first_res.last_of_run && push.second_res.last_of_run))
      else $error("wrong end-of-run mark on a two-result byte");

endmodule

// ===== tb/bmp_tb_pkg.sv =====
package bmp_tb_pkg;

   import bsp_pkg::*;

   // configuration register indexes
   localparam logic REG_MAX_COLUMNS = 1'b0;
   localparam logic REG_MAX_ROWS    = 1'b1;

   // extremes of the size limits
   localparam dim_type LIMIT_BOTTOM = dim_type'(1);
   localparam dim_type LIMIT_TOP    = '1;

   // bitmap header layout
   localparam int HEADER_BYTES  = 54;
   localparam int WIDTH_OFFSET  = 18;
   localparam int HEIGHT_OFFSET = 22;
   localparam int DEPTH_OFFSET  = 28;

   localparam logic [15:0] REQUIRED_DEPTH = 16'd24;

   // signature characters 'B' and 'M'
   localparam logic [7:0] SIG_FIRST  = 8'h42;
   localparam logic [7:0] SIG_SECOND = 8'h4D;

   // wait after a drain for an in-flight byte to clear the block
   localparam int SETTLE_CYCLES = 8;

endpackage

// ===== tb/bmp_checker.sv =====
module bmp_checker import bsp_pkg::*; import bmp_tb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  kind_type   rsp_kind,
   input  logic [7:0] rsp_red,
   input  logic [7:0] rsp_green,
   input  logic [7:0] rsp_blue,
   input  dim_type    rsp_pixel_row,
   input  dim_type    rsp_pixel_column,
   input  dim_type    rsp_image_width,
   input  dim_type    rsp_image_height,
   input  logic       rsp_last_of_run,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_index,
   input  dim_type    csr_wdata,
   output int         fail_count,
   output int         pending_count,
   output int         results_checked
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_HEADER,
      MODE_PIXELS,
      MODE_PADDING
   } parse_mode_type;

   localparam int HDR_LAST = HEADER_BYTES - 1;

   // limits as last written
   dim_type max_columns;
   dim_type max_rows;

   // parser state
   parse_mode_type parse_mode;
   logic [5:0]     header_index;
   logic [31:0]    width_word;
   logic [31:0]    height_word;
   logic [15:0]    depth_word;
   logic           signature_ok;
   logic [7:0]     held_blue;
   logic [7:0]     held_green;
   logic [1:0]     byte_phase;
   dim_type        column_count;
   dim_type        row_count;
   logic [1:0]     padding_left;

   result_type awaited_results[$];
   result_type byte_results[$];
   result_type oldest;
   int         mismatches;
   int         checked;

   function automatic void add_result(kind_type kind, logic [7:0] red, logic [7:0] green,
                                      logic [7:0] blue, dim_type row, dim_type column,
                                      dim_type width, dim_type height);
      result_type res;
      res              = '0;
      res.kind         = kind;
      res.red          = red;
      res.green        = green;
      res.blue         = blue;
      res.pixel_row    = row;
      res.pixel_column = column;
      res.image_width  = width;
      res.image_height = height;
      byte_results.push_back(res);
   endfunction

   function automatic void clear_parse();
      header_index = '0;
      width_word   = '0;
      height_word  = '0;
      depth_word   = '0;
      signature_ok = 1'b0;
      held_blue    = '0;
      held_green   = '0;
      byte_phase   = '0;
      column_count = '0;
      row_count    = '0;
      padding_left = '0;
   endfunction

   // close a row, returns 1 when the image is complete
   function automatic bit finish_row();
      column_count = '0;
      row_count    = row_count + 1'b1;
      if (32'(row_count) == height_word) begin
         add_result(KIND_COMPLETE, '0, '0, '0, '0, '0, '0, '0);
         parse_mode = MODE_IDLE;
         return 1'b1;
      end
      parse_mode = MODE_PIXELS;
      return 1'b0;
   endfunction

   // expected results of one accepted byte
   task automatic decode_byte(logic [7:0] data, logic is_first, logic is_last);
      int pos;
      bit done;
      bit header_ok;
      byte_results.delete();
      if (is_first) begin
         parse_mode = MODE_HEADER;
         clear_parse();
      end
      if (parse_mode == MODE_HEADER) begin
         pos = int'(header_index);
         // signature and little-endian field capture
         if (pos == 0) begin
            signature_ok = (data == SIG_FIRST);
         end else if (pos == 1) begin
            signature_ok = signature_ok && (data == SIG_SECOND);
            if (!signature_ok) begin
               add_result(KIND_BAD, '0, '0, '0, '0, '0, '0, '0);
               parse_mode = MODE_IDLE;
            end
         end else if (pos >= WIDTH_OFFSET && pos < WIDTH_OFFSET + 4) begin
            width_word = width_word | (32'(data) << (8 * (pos - WIDTH_OFFSET)));
         end else if (pos >= HEIGHT_OFFSET && pos < HEIGHT_OFFSET + 4) begin
            height_word = height_word | (32'(data) << (8 * (pos - HEIGHT_OFFSET)));
         end else if (pos >= DEPTH_OFFSET && pos < DEPTH_OFFSET + 2) begin
            depth_word = depth_word | (16'(data) << (8 * (pos - DEPTH_OFFSET)));
         end
         if (parse_mode == MODE_HEADER) begin
            if (pos == HDR_LAST) begin
               // validate the header
               header_ok = width_word >= 1 && width_word <= 32'(max_columns) &&
                           height_word >= 1 && height_word <= 32'(max_rows) &&
                           depth_word == REQUIRED_DEPTH;
               if (!header_ok) begin
                  add_result(KIND_BAD, '0, '0, '0, '0, '0, '0, '0);
                  parse_mode = MODE_IDLE;
               end else begin
                  add_result(KIND_ACCEPT, '0, '0, '0, '0, '0,
                             width_word[DIM_BITS-1:0], height_word[DIM_BITS-1:0]);
                  parse_mode   = MODE_PIXELS;
                  byte_phase   = '0;
                  column_count = '0;
                  row_count    = '0;
                  padding_left = '0;
                  if (is_last) begin
                     add_result(KIND_PREMATURE, '0, '0, '0, '0, '0, '0, '0);
                     parse_mode = MODE_IDLE;
                  end
               end
            end else if (is_last) begin
               add_result(KIND_BAD, '0, '0, '0, '0, '0, '0, '0);
               parse_mode = MODE_IDLE;
            end else begin
               header_index = header_index + 1'b1;
            end
         end
      end else if (parse_mode == MODE_PIXELS || parse_mode == MODE_PADDING) begin
         done = 1'b0;
         if (parse_mode == MODE_PADDING) begin
            padding_left = padding_left - 1'b1;
            if (padding_left == 0) done = finish_row();
         end else if (byte_phase == 0) begin
            held_blue  = data;
            byte_phase = 2'd1;
         end else if (byte_phase == 1) begin
            held_green = data;
            byte_phase = 2'd2;
         end else begin
            // red byte completes a pixel
            add_result(KIND_PIXEL, data, held_green, held_blue, row_count, column_count,
                       '0, '0);
            byte_phase   = '0;
            column_count = column_count + 1'b1;
            if (32'(column_count) == width_word) begin
               padding_left = width_word[1:0];
               if (padding_left == 0) done = finish_row();
               else parse_mode = MODE_PADDING;
            end
         end
         if (!done && is_last) begin
            add_result(KIND_PREMATURE, '0, '0, '0, '0, '0, '0, '0);
            parse_mode = MODE_IDLE;
         end
      end
      if (byte_results.size() > 0) byte_results[byte_results.size()-1].last_of_run = 1'b1;
      foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
   endtask

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      checked    = 0;
   end

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         max_columns = LIMIT_RESET;
         max_rows    = LIMIT_RESET;
         parse_mode  = MODE_IDLE;
         clear_parse();
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_MAX_COLUMNS) max_columns = csr_wdata;
            else max_rows = csr_wdata;
         end
         // compare a result transfer with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, rsp_kind);
               mismatches++;
            end else begin
               oldest = awaited_results.pop_front();
               check_field("kind", oldest.kind, rsp_kind);
               check_field("red", oldest.red, rsp_red);
               check_field("green", oldest.green, rsp_green);
               check_field("blue", oldest.blue, rsp_blue);
               check_field("pixel_row", oldest.pixel_row, rsp_pixel_row);
               check_field("pixel_column", oldest.pixel_column, rsp_pixel_column);
               check_field("image_width", oldest.image_width, rsp_image_width);
               check_field("image_height", oldest.image_height, rsp_image_height);
               check_field("last_of_run", oldest.last_of_run, rsp_last_of_run);
               checked++;
            end
         end
         if (req_valid && req_ready) decode_byte(req_data_byte, req_first_byte, req_last_byte);
      end
      fail_count      <= mismatches;
      pending_count   <= awaited_results.size();
      results_checked <= checked;
   end

endmodule

// ===== tb/tb.sv =====
module tb;

   import bsp_pkg::*;
   import bmp_tb_pkg::*;

   localparam int RANDOM_ITEMS    = 850;
   localparam int PHASE_ITEMS     = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int TIMEOUT_CYCLES  = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = '0;
   logic       req_first_byte = 1'b0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   kind_type   rsp_kind;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   dim_type    rsp_pixel_row;
   dim_type    rsp_pixel_column;
   dim_type    rsp_image_width;
   dim_type    rsp_image_height;
   logic       rsp_last_of_run;
   logic       csr_valid = 1'b0;
   logic       csr_index = REG_MAX_COLUMNS;
   dim_type    csr_wdata = '0;
   logic       csr_ready;

   int fail_count;
   int pending_count;
   int results_checked;

   // stimulus bookkeeping
   logic [7:0] file_bytes[$];
   dim_type    cur_max_columns = LIMIT_RESET;
   dim_type    cur_max_rows = LIMIT_RESET;
   int         bytes_sent = 0;
   int         stray_sent = 0;
   int         files_sent = 0;
   int         limit_settings = 0;
   int         burst_left = 0;
   bit         hold_off_request = 1'b0;
   bit         hold_off_done = 1'b0;

   bmp24_stream_parser u_dut (.*);

   bmp_checker u_checker (
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .*
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_CYCLES * 4);
      $display("tb failed");
      $finish;
   end

   // receiver: ready pattern changes every so often, long hold-off on request
   initial begin : receiver
      int stall_mode;
      int span;
      int tick;
      tick = 0;
      forever begin
         stall_mode = $urandom_range(0, 3);
         span       = $urandom_range(10, 150);
         repeat (span) begin
            @(negedge clock);
            tick++;
            if (hold_off_request) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
               hold_off_request = 1'b0;
            end
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   // one byte transfer, bursts separated by random gaps
   task automatic send_byte(logic [7:0] data, logic is_first, logic is_last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 24);
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_first_byte <= is_first;
      req_last_byte  <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   // drain, then write both size limits
   task automatic write_limits(dim_type cols, dim_type rows);
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      for (int r = 0; r < 2; r++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= (r == 0) ? REG_MAX_COLUMNS : REG_MAX_ROWS;
         csr_wdata <= (r == 0) ? cols : rows;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_max_columns = cols;
      cur_max_rows    = rows;
      limit_settings++;
   endtask

   // header with random filler, pixel rows only for small accepted images
   task automatic build_file(logic [31:0] w, logic [31:0] h, logic [15:0] depth);
      logic [7:0] b;
      file_bytes.delete();
      for (int i = 0; i < HEADER_BYTES; i++) begin
         b = 8'($urandom_range(0, 255));
         if (i == 0) b = SIG_FIRST;
         if (i == 1) b = SIG_SECOND;
         if (i >= WIDTH_OFFSET && i < WIDTH_OFFSET + 4) b = 8'(w >> (8 * (i - WIDTH_OFFSET)));
         if (i >= HEIGHT_OFFSET && i < HEIGHT_OFFSET + 4)
            b = 8'(h >> (8 * (i - HEIGHT_OFFSET)));
         if (i >= DEPTH_OFFSET && i < DEPTH_OFFSET + 2)
            b = 8'(depth >> (8 * (i - DEPTH_OFFSET)));
         file_bytes.push_back(b);
      end
      if (w >= 1 && w <= 32'(cur_max_columns) && h >= 1 && h <= 32'(cur_max_rows) &&
          depth == REQUIRED_DEPTH && w <= 16 && h <= 8) begin
         for (int r = 0; r < h; r++) begin
            for (int c = 0; c < 3 * w; c++) file_bytes.push_back(8'($urandom_range(0, 255)));
            for (int p = 0; p < w % 4; p++) file_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // send the first count bytes of the file, marking byte last_at as final
   task automatic send_file(int count, int last_at);
      for (int i = 0; i < count && i < file_bytes.size(); i++) begin
         send_byte(file_bytes[i], i == 0, i == last_at);
         bytes_sent++;
      end
      files_sent++;
   endtask

   task automatic send_noise(int count);
      repeat (count) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         stray_sent++;
      end
   endtask

   initial begin : stimulus
      int random_start;
      int next_phase_at;
      int phase;
      int pick;
      int len;
      int cut;
      logic [31:0] w;
      logic [31:0] h;
      logic [15:0] depth;
      int guard;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle noise, one-byte file, each signature byte wrong in turn
      send_noise(3);
      build_file(2, 2, REQUIRED_DEPTH);
      send_file(1, 0);
      file_bytes[0] = 8'h41;
      send_file(3, -1);
      file_bytes[0] = SIG_FIRST;
      file_bytes[1] = 8'h4E;
      send_file(2, -1);

      // header cut short, last on the final header byte with good and bad size
      build_file(3, 2, REQUIRED_DEPTH);
      send_file(20, 19);
      send_file(HEADER_BYTES, HEADER_BYTES - 1);
      build_file(0, 2, REQUIRED_DEPTH);
      send_file(HEADER_BYTES, HEADER_BYTES - 1);

      // invalid headers: zero height, wrong depth, too wide, negative width
      build_file(3, 0, REQUIRED_DEPTH);
      send_file(HEADER_BYTES, -1);
      build_file(3, 2, 16'h0118);
      send_file(HEADER_BYTES, -1);
      build_file(32'(LIMIT_RESET) + 1, 2, REQUIRED_DEPTH);
      send_file(HEADER_BYTES, -1);
      build_file(32'hFFFF_FFFF, 2, REQUIRED_DEPTH);
      send_file(HEADER_BYTES, -1);

      // completion with last on the completing padding byte, then unpadded rows
      build_file(1, 1, REQUIRED_DEPTH);
      send_file(file_bytes.size(), file_bytes.size() - 1);
      build_file(4, 2, REQUIRED_DEPTH);
      send_file(file_bytes.size(), -1);
      send_noise(2);

      // early end on a red byte, in padding, and on a blue byte
      build_file(5, 2, REQUIRED_DEPTH);
      send_file(HEADER_BYTES + 3, HEADER_BYTES + 2);
      build_file(2, 2, REQUIRED_DEPTH);
      send_file(HEADER_BYTES + 7, HEADER_BYTES + 6);
      build_file(3, 1, REQUIRED_DEPTH);
      send_file(HEADER_BYTES + 1, HEADER_BYTES);

      // restart in the middle of a file
      build_file(3, 3, REQUIRED_DEPTH);
      send_file(30, -1);
      build_file(1, 2, REQUIRED_DEPTH);
      send_file(file_bytes.size(), -1);

      // lowest limits
      write_limits(LIMIT_BOTTOM, LIMIT_BOTTOM);
      build_file(1, 1, REQUIRED_DEPTH);
      send_file(file_bytes.size(), -1);
      build_file(2, 1, REQUIRED_DEPTH);
      send_file(HEADER_BYTES, -1);
      build_file(1, 2, REQUIRED_DEPTH);
      send_file(HEADER_BYTES, -1);

      // highest limits: largest image accepted, a few pixels, then cut
      write_limits(LIMIT_TOP, LIMIT_TOP);
      build_file(32'(LIMIT_TOP), 32'(LIMIT_TOP), REQUIRED_DEPTH);
      repeat (9) file_bytes.push_back(8'($urandom_range(0, 255)));
      send_file(file_bytes.size(), file_bytes.size() - 1);
      build_file(32'(LIMIT_TOP) + 1, 1, REQUIRED_DEPTH);
      send_file(HEADER_BYTES, -1);
      write_limits(LIMIT_RESET, LIMIT_RESET);

      // random part: mostly well-formed files, the rest broken or noise
      random_start  = bytes_sent;
      next_phase_at = PHASE_ITEMS;
      phase         = 0;
      while (bytes_sent - random_start < RANDOM_ITEMS) begin
         if (bytes_sent - random_start >= next_phase_at) begin
            next_phase_at += PHASE_ITEMS;
            case (phase % 5)
               0: write_limits(LIMIT_TOP, LIMIT_TOP);
               1: write_limits(LIMIT_BOTTOM, LIMIT_BOTTOM);
               2: write_limits(dim_type'($urandom_range(1, 8)),
                               dim_type'($urandom_range(1, 5)));
               3: write_limits(dim_type'($urandom_range(3, 7)),
                               dim_type'($urandom_range(2, 4)));
               default: write_limits(LIMIT_RESET, LIMIT_RESET);
            endcase
            phase++;
         end
         if (!hold_off_done && bytes_sent - random_start > 600) begin
            hold_off_request = 1'b1;
            hold_off_done    = 1'b1;
         end
         w     = $urandom_range(1, 7);
         h     = $urandom_range(1, 4);
         depth = REQUIRED_DEPTH;
         pick  = $urandom_range(0, 99);
         if (pick < 60) begin
            build_file(w, h, depth);
            len = file_bytes.size();
            send_file(len, ($urandom_range(0, 1) != 0) ? len - 1 : -1);
            if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 3));
         end else if (pick < 70) begin
            // truncated with last, mostly inside the image
            build_file(w, h, depth);
            len = file_bytes.size();
            if (len > HEADER_BYTES && $urandom_range(0, 9) > 2)
               cut = $urandom_range(HEADER_BYTES, len - 1);
            else
               cut = $urandom_range(1, HEADER_BYTES - 1);
            send_file(cut + 1, cut);
         end else if (pick < 75) begin
            // cut off without last, the next file restarts the parse
            build_file(w, h, depth);
            send_file($urandom_range(1, file_bytes.size() - 1), -1);
         end else if (pick < 85) begin
            // one header field out of range
            case ($urandom_range(0, 5))
               0: w = 0;
               1: w = 32'(cur_max_columns) + 1;
               2: h = 0;
               3: h = 32'(cur_max_rows) + 1;
               4: w = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
               default: depth = 16'($urandom_range(0, 65535));
            endcase
            build_file(w, h, depth);
            send_file(file_bytes.size(), -1);
         end else if (pick < 90) begin
            // broken signature
            build_file(w, h, depth);
            if ($urandom_range(0, 1) != 0)
               while (file_bytes[0] == SIG_FIRST) file_bytes[0] = 8'($urandom_range(0, 255));
            else
               while (file_bytes[1] == SIG_SECOND) file_bytes[1] = 8'($urandom_range(0, 255));
            send_file($urandom_range(2, 6), -1);
         end else if (pick < 95) begin
            // short header, one-byte file included
            build_file(w, h, depth);
            cut = $urandom_range(0, HEADER_BYTES - 2);
            send_file(cut + 1, cut);
         end else begin
            send_noise($urandom_range(1, 5));
         end
      end

      // drain and settle
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (pending_count != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES * 2) @(negedge clock);
      if (pending_count != 0)
         $display("%0t: %0d expected results never arrived", $time, pending_count);

      $display("sent %0d file bytes in %0d files plus %0d stray bytes, %0d limit settings",
               bytes_sent, files_sent, stray_sent, limit_settings);
      $display("checked %0d results, with a long result stall and drains before writes",
               results_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bsp_pkg.sv
sv/bsp_parse_core.sv
sv/bsp_rsp_fifo.sv
sv/bmp24_stream_parser.sv
tb/bmp_tb_pkg.sv
tb/bmp_checker.sv
tb/tb.sv
